// ===== src/bfdh_pkg.sv =====
// package for the bloom filter double hash unit: sizes, codes, state and struct types
package bfdh_pkg;

  // table geometry
  localparam int unsigned MAX_TABLE_BITS = 65536;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned BIT_OFS_W      = $clog2(WORD_W);
  localparam int unsigned WORD_COUNT     = (MAX_TABLE_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned WORD_AW        = $clog2(WORD_COUNT);

  // field and register widths
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned PROBE_W = 7;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // register limits and reset values
  localparam logic [PROBE_W-1:0] PROBE_MIN    = PROBE_W'(1);
  localparam logic [PROBE_W-1:0] PROBE_LIMIT  = PROBE_W'(64);
  localparam logic [PROBE_W-1:0] PROBE_RESET  = PROBE_W'(10);
  localparam logic [SIZE_W-1:0]  SIZE_MIN     = SIZE_W'(64);
  localparam logic [SIZE_W-1:0]  SIZE_MAX     = SIZE_W'(MAX_TABLE_BITS);
  localparam logic [SIZE_W-1:0]  SIZE_RESET   = SIZE_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  // modulo unit: two quotient bits per cycle
  localparam int unsigned MOD_STEPS = HASH_W / 2;
  localparam int unsigned MOD_CW    = $clog2(MOD_STEPS);

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // register indexes
  localparam logic REG_PROBE_COUNT = 1'b0;
  localparam logic REG_TABLE_BITS  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_MOD_H,
    S_MOD_S,
    S_MOD_K,
    S_READ,
    S_CHECK,
    S_FINISH
  } bfdh_state_e;

  // configuration register values
  typedef struct packed {
    logic [PROBE_W-1:0] probe_count;
    logic [SIZE_W-1:0]  table_bits;
  } cfg_t;

  // modulo unit request
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  // modulo unit response
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== src/bfdh_in_if.sv =====
// input channel: operation word with the two hash halves
interface bfdh_in_if
  import bfdh_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [HASH_W-1:0] hash_first;
  logic [HASH_W-1:0] hash_second;

  modport source (output valid, kind, hash_first, hash_second, input ready);
  modport sink   (input valid, kind, hash_first, hash_second, output ready);
endinterface

// ===== src/bfdh_out_if.sv =====
// output channel: query answer and element count word
interface bfdh_out_if
  import bfdh_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               maybe_present;
  logic [COUNT_W-1:0] element_count;

  modport source (output valid, maybe_present, element_count, input ready);
  modport sink   (input valid, maybe_present, element_count, output ready);
endinterface

// ===== src/bfdh_ram.sv =====
// generic single write port ram with registered read
module bfdh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bfdh_mod.sv =====
// iterative 64-bit by 17-bit remainder unit, two bits per cycle
module bfdh_mod
  import bfdh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [MOD_CW-1:0] cnt_q, cnt_d;
  logic [HASH_W-1:0] dvd_q, dvd_d;
  logic [SIZE_W-1:0] div_q, div_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] rem_mid;

  // one restoring step: shift in a bit, subtract divisor if it fits
  function automatic logic [SIZE_W-1:0] mod_step(input logic [SIZE_W-1:0] r,
                                                 input logic               b,
                                                 input logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] t;
    logic [SIZE_W:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      mod_step = s[SIZE_W-1:0];
    end else begin
      mod_step = t[SIZE_W-1:0];
    end
  endfunction

  // step logic
  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    div_d   = div_q;
    rem_d   = rem_q;
    rem_mid = mod_step(rem_q, dvd_q[HASH_W-1], div_q);
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = req_i.dividend;
      div_d = req_i.divisor;
      rem_d = '0;
    end else if (run_q) begin
      rem_d = mod_step(rem_mid, dvd_q[HASH_W-2], div_q);
      dvd_d = {dvd_q[HASH_W-3:0], 2'b00};
      cnt_d = cnt_q + MOD_CW'(1);
      if (cnt_q == MOD_CW'(MOD_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== src/bfdh_regs.sv =====
// apb configuration registers: probe count and table size
module bfdh_regs
  import bfdh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_PROBE_COUNT: cfg_d.probe_count = pwdata[PROBE_W-1:0];
        REG_TABLE_BITS:  cfg_d.table_bits  = pwdata[SIZE_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_PROBE_COUNT: prdata = APB_DW'(cfg_q.probe_count);
      REG_TABLE_BITS:  prdata = APB_DW'(cfg_q.table_bits);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.probe_count <= PROBE_RESET;
      cfg_q.table_bits  <= SIZE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/bloom_filter_double_hash_unit.sv =====
// top level: bloom filter bit table with double hashing and probe sequencer
//
// in_i carries one word per operation: kind (insert, query, clear),
// hash_first (base) and hash_second (stride, forced odd). out_o returns
// one word per operation: maybe_present and the element count after it.
// the user writes configuration (probe_count, table_bits) over the apb port
// only while the block is idle; the block itself does not enforce this.
// insert and query: one shared iterative remainder unit reduces the base,
// the stride and 2^64 by the table size in turn; then each probe is a table
// read and then a check or write back. a query stops at the first clear bit.
// clear: the 1024-word table is swept one word a cycle.
// after reset the same sweep runs before the first word is taken;
// apb writes are accepted meanwhile.
// a result sits in an output register; the next word is accepted while it
// waits, but a finished operation holds in its final state until the
// receiver takes the previous result.
module bloom_filter_double_hash_unit
  import bfdh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  bfdh_in_if.sink           in_i,
  bfdh_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  bfdh_state_e state_q, state_d;

  cfg_t     cfg;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // control registers
  logic [WORD_AW-1:0] clr_q;
  logic               clear_op_q;
  logic [PROBE_W-1:0] i_q;
  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q;

  // operation registers
  logic [KIND_W-1:0]  kind_q;
  logic [HASH_W-1:0]  x_q;
  logic [HASH_W-1:0]  stride_q;
  logic [PROBE_W-1:0] n_q;
  logic [SIZE_W-1:0]  size_q;
  logic [SIZE_W-1:0]  r_q;
  logic [SIZE_W-1:0]  sm_q;
  logic [SIZE_W-1:0]  k_q;
  logic               present_q;
  logic               out_present_q;
  logic [COUNT_W-1:0] out_count_q;

  // effective configuration
  logic [PROBE_W-1:0] n_eff;
  logic [SIZE_W-1:0]  size_eff;

  // probe arithmetic
  logic [HASH_W-1:0]  x_sum;
  logic               x_carry;
  logic [SIZE_W:0]    t_sum, t_red, t_sub;
  logic [SIZE_W-1:0]  r_nxt;
  logic [SIZE_W:0]    k_inc;
  logic               probe_bit;
  logic               last_probe;
  logic               in_fire;
  logic               out_load;

  // table ram
  logic               ram_we, ram_re;
  logic [WORD_AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  bfdh_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bfdh_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  bfdh_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // clamp configuration to its working range
  always_comb begin
    if (cfg.probe_count < PROBE_MIN) begin
      n_eff = PROBE_MIN;
    end else if (cfg.probe_count > PROBE_LIMIT) begin
      n_eff = PROBE_LIMIT;
    end else begin
      n_eff = cfg.probe_count;
    end
    if (cfg.table_bits < SIZE_MIN) begin
      size_eff = SIZE_MIN;
    end else if (cfg.table_bits > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = cfg.table_bits;
    end
  end

  // next probe index: add stride mod size, fold back 2^64 on wrap
  always_comb begin
    {x_carry, x_sum} = {1'b0, x_q} + {1'b0, stride_q};
    t_sum = {1'b0, r_q} + {1'b0, sm_q};
    t_red = (t_sum >= {1'b0, size_q}) ? t_sum - {1'b0, size_q} : t_sum;
    t_sub = (t_red >= {1'b0, k_q}) ? t_red - {1'b0, k_q}
                                   : t_red + {1'b0, size_q} - {1'b0, k_q};
    r_nxt = x_carry ? t_sub[SIZE_W-1:0] : t_red[SIZE_W-1:0];
    k_inc = {1'b0, mod_rsp.rem} + (SIZE_W+1)'(1);
  end

  assign probe_bit  = ram_rdata[r_q[BIT_OFS_W-1:0]];
  assign last_probe = (i_q + PROBE_W'(1)) == n_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (in_i.kind)
            KIND_INSERT, KIND_QUERY: state_d = S_MOD_H;
            KIND_CLEAR:              state_d = S_CLEAR;
            default:                 state_d = S_FINISH;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_q == WORD_AW'(WORD_COUNT - 1)) begin
          state_d = clear_op_q ? S_FINISH : S_IDLE;
        end
      end
      S_MOD_H: if (mod_rsp.done) state_d = S_MOD_S;
      S_MOD_S: if (mod_rsp.done) state_d = S_MOD_K;
      S_MOD_K: if (mod_rsp.done) state_d = S_READ;
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (last_probe || (kind_q == KIND_QUERY && !probe_bit)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_READ;
        end
      end
      S_FINISH: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready       = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = x_q;
    mod_req.divisor  = size_q;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = r_q[WORD_AW+BIT_OFS_W-1:BIT_OFS_W];
    ram_raddr        = r_q[WORD_AW+BIT_OFS_W-1:BIT_OFS_W];
    ram_wdata        = ram_rdata | (WORD_W'(1) << r_q[BIT_OFS_W-1:0]);
    case (state_q)
      S_IDLE: begin
        in_i.ready       = 1'b1;
        mod_req.dividend = in_i.hash_first;
        mod_req.divisor  = size_eff;
        mod_req.start    = in_i.valid &&
                           (in_i.kind == KIND_INSERT || in_i.kind == KIND_QUERY);
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_MOD_H: begin
        mod_req.dividend = stride_q;
        mod_req.start    = mod_rsp.done;
      end
      S_MOD_S: begin
        mod_req.dividend = '1;
        mod_req.start    = mod_rsp.done;
      end
      S_READ:  ram_re = 1'b1;
      S_CHECK: ram_we = (kind_q == KIND_INSERT);
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clear_op_q  <= 1'b0;
      i_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + WORD_AW'(1);
      end
      if (in_fire) begin
        clear_op_q <= (in_i.kind == KIND_CLEAR);
        if (in_i.kind == KIND_CLEAR) begin
          count_q <= '0;
        end
      end
      if (state_q == S_MOD_K) begin
        i_q <= '0;
      end else if (state_q == S_CHECK) begin
        i_q <= i_q + PROBE_W'(1);
        if (kind_q == KIND_INSERT && last_probe && count_q != COUNT_MAX) begin
          count_q <= count_q + COUNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operation datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_q    <= in_i.kind;
          x_q       <= in_i.hash_first;
          stride_q  <= in_i.hash_second | HASH_W'(1);
          n_q       <= n_eff;
          size_q    <= size_eff;
          present_q <= (in_i.kind == KIND_QUERY);
        end
      end
      S_MOD_H: if (mod_rsp.done) r_q  <= mod_rsp.rem;
      S_MOD_S: if (mod_rsp.done) sm_q <= mod_rsp.rem;
      S_MOD_K: begin
        if (mod_rsp.done) begin
          k_q <= (k_inc == {1'b0, size_q}) ? '0 : k_inc[SIZE_W-1:0];
        end
      end
      S_CHECK: begin
        if (kind_q == KIND_QUERY && !probe_bit) begin
          present_q <= 1'b0;
        end
        x_q <= x_sum;
        r_q <= r_nxt;
      end
      S_FINISH: begin
        if (out_load) begin
          out_present_q <= present_q;
          out_count_q   <= count_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.maybe_present = out_present_q;
  assign out_o.element_count = out_count_q;

`ifndef SYNTHESIS
  // a new result is only loaded from the final state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FINISH)
    else $error("result loaded outside finish state");

  // probed bit index stays inside the table in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_CHECK) |-> r_q < size_q)
    else $error("probe index beyond table size");

  // probe counter never reaches the probe count while probing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> i_q < n_q)
    else $error("probe counter overrun");

  // remainder unit is only started when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_req.start |-> !mod_rsp.busy)
    else $error("remainder unit started while busy");
`endif

endmodule
